>>> design/csvg_pkg.sv
`timescale 1ns / 1ps

package csvg_pkg;

  // Field widths
  localparam int IDX_W  = 12;
  localparam int SEG_W  = 13;
  localparam int RAD_W  = 16;
  localparam int DAT_W  = 16;
  localparam int U_W    = 17;
  localparam int TRIG_W = 16;
  localparam int POS_W  = 18;
  localparam int DVD_W  = 29;

  localparam logic [SEG_W-1:0] SEG_MIN     = 13'd3;
  localparam logic [SEG_W-1:0] SEG_CFG_MAX = 13'd8191;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SEGMENTS      = 2'd0,
    REG_TOP_RADIUS    = 2'd1,
    REG_BOTTOM_RADIUS = 2'd2,
    REG_HEIGHT        = 2'd3
  } cfg_reg_t;

  // Vertex order within one segment
  typedef enum logic [2:0] {
    CRN_TOP0   = 3'd0,
    CRN_BOT0_A = 3'd1,
    CRN_TOP1_A = 3'd2,
    CRN_BOT0_B = 3'd3,
    CRN_BOT1   = 3'd4,
    CRN_TOP1_B = 3'd5
  } corner_t;

  // Taylor series constants, unsigned Q2.30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [32:0] RCP_NUM = 33'h1_0000_0000;
  localparam int          NSTEP   = 3;

  localparam logic [6:0]  SIN_DIV0 = 7'd72;
  localparam logic [6:0]  COS_DIV0 = 7'd90;
  localparam logic [29:0] SIN_RCP0 = 30'(RCP_NUM / 72);
  localparam logic [29:0] COS_RCP0 = 30'(RCP_NUM / 90);

  localparam logic [6:0] SIN_DIV [0:NSTEP-1] = '{7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [0:NSTEP-1] = '{7'd56, 7'd30, 7'd12};
  localparam logic [29:0] SIN_RCP [0:NSTEP-1] =
    '{30'(RCP_NUM / 42), 30'(RCP_NUM / 20), 30'(RCP_NUM / 6)};
  localparam logic [29:0] COS_RCP [0:NSTEP-1] =
    '{30'(RCP_NUM / 56), 30'(RCP_NUM / 30), 30'(RCP_NUM / 12)};

  // Phase job from the divider
  typedef struct packed {
    logic           valid;
    logic           job;
    logic [U_W-1:0] u;
  } phase_t;

  // Sine and cosine of one phase
  typedef struct packed {
    logic                     valid;
    logic                     job;
    logic [U_W-1:0]           u;
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  // Sideband that travels with the sine/cosine pipeline
  typedef struct packed {
    logic           job;
    logic [U_W-1:0] u;
    logic [1:0]     quad;
    logic           fold;
  } trig_side_t;

  // Reciprocal estimate is floor or one below: bump it once if needed
  function automatic logic [29:0] fix_quot(input logic [27:0] q_est,
                                           input logic [29:0] v,
                                           input logic [6:0]  d);
    logic [36:0] qd;
    logic [36:0] rem;
    qd  = 37'(q_est) * 37'(d);
    rem = 37'(v) - qd;
    if (rem >= 37'(d)) begin
      return 30'(q_est) + 30'd1;
    end
    return 30'(q_est);
  endfunction

endpackage

>>> design/csvg_div.sv
`timescale 1ns / 1ps

module csvg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic                          in_job,
  input  logic [csvg_pkg::DVD_W-1:0]    dividend,
  input  logic [csvg_pkg::SEG_W-1:0]    divisor,
  output csvg_pkg::phase_t              ph_out
);
  import csvg_pkg::*;

  localparam int QW = U_W;

  logic [QW:0]       vld_r;
  logic [QW:0]       job_r;
  logic [SEG_W-1:0]  rem_r [0:QW];
  logic [QW-1:0]     low_r [0:QW];

  // Advance valid bits, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [SEG_W:0] trial;
    logic           ge;
    job_r    <= {job_r[QW-1:0], in_job};
    rem_r[0] <= SEG_W'(dividend[DVD_W-1:QW]);
    low_r[0] <= dividend[QW-1:0];
    for (int s = 0; s < QW; s++) begin
      trial = {rem_r[s], low_r[s][QW-1]};
      ge    = trial >= {1'b0, divisor};
      rem_r[s+1] <= ge ? SEG_W'(trial - {1'b0, divisor}) : trial[SEG_W-1:0];
      low_r[s+1] <= {low_r[s][QW-2:0], ge};
    end
  end

  assign ph_out.valid = vld_r[QW];
  assign ph_out.job   = job_r[QW];
  assign ph_out.u     = low_r[QW];

endmodule

>>> design/csvg_sincos.sv
`timescale 1ns / 1ps

module csvg_sincos (
  input  logic             clk,
  input  logic             rst_n,
  input  csvg_pkg::phase_t ph_in,
  output csvg_pkg::trig_t  trig_out
);
  import csvg_pkg::*;

  localparam int NST = 5 + 3 * NSTEP + 2;

  logic [NST-1:0] vld_r;
  trig_side_t     side_r [0:NST-1];

  // Front stages
  logic [13:0] a_r;
  logic [45:0] xp_r;
  logic [59:0] x2p_r;
  logic [29:0] x3_r;
  logic [59:0] ps_r, pc_r;
  logic [29:0] x2_4_r, x_4_r;

  // Taylor steps: boundary values and inner stages
  logic [30:0] ts_q [0:NSTEP];
  logic [30:0] tc_q [0:NSTEP];
  logic [29:0] x2_q [0:NSTEP];
  logic [29:0] x_q  [0:NSTEP];
  logic [59:0] ms_r [0:NSTEP-1];
  logic [59:0] mc_r [0:NSTEP-1];
  logic [59:0] ds_r [0:NSTEP-1];
  logic [59:0] dc_r [0:NSTEP-1];
  logic [29:0] vs_r [0:NSTEP-1];
  logic [29:0] vc_r [0:NSTEP-1];
  logic [29:0] x2a_r [0:NSTEP-1];
  logic [29:0] xa_r  [0:NSTEP-1];
  logic [29:0] x2b_r [0:NSTEP-1];
  logic [29:0] xb_r  [0:NSTEP-1];

  // Back stages
  logic [59:0]              so_p_r, co_p_r;
  logic signed [TRIG_W-1:0] sn_r, cs_r;

  // Octant fold of the input phase
  logic [13:0]  r_w;
  logic         fold_w;
  logic [14:0]  a_w;
  trig_side_t   side_w;

  always_comb begin
    r_w         = ph_in.u[13:0];
    fold_w      = r_w > 14'd8192;
    a_w         = fold_w ? (15'd16384 - {1'b0, r_w}) : {1'b0, r_w};
    side_w.job  = ph_in.job;
    side_w.u    = ph_in.u;
    side_w.quad = ph_in.u[15:14];
    side_w.fold = fold_w;
  end

  // Round, unfold and place in the quadrant
  logic [29:0]              so_w, cm_w;
  logic [30:0]              co_w, s_rnd, c_rnd;
  logic signed [TRIG_W-1:0] s_w, c_w, rs_w, rc_w, sn_w, cs_w;
  trig_side_t               sg_w;

  always_comb begin
    sg_w  = side_r[NST-2];
    so_w  = so_p_r[59:30];
    cm_w  = co_p_r[59:30];
    co_w  = Q30_ONE - 31'(cm_w >> 1);
    s_rnd = 31'(so_w) + 31'd32768;
    c_rnd = co_w + 31'd32768;
    s_w   = {1'b0, s_rnd[30:16]};
    c_w   = {1'b0, c_rnd[30:16]};
    rs_w  = sg_w.fold ? c_w : s_w;
    rc_w  = sg_w.fold ? s_w : c_w;
    unique case (sg_w.quad)
      2'd0: begin
        sn_w = rs_w;
        cs_w = rc_w;
      end
      2'd1: begin
        sn_w = rc_w;
        cs_w = -rs_w;
      end
      2'd2: begin
        sn_w = -rs_w;
        cs_w = -rc_w;
      end
      2'd3: begin
        sn_w = -rc_w;
        cs_w = rs_w;
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], ph_in.valid};
    end
  end

  // Advance sideband
  always_ff @(posedge clk) begin
    side_r[0] <= side_w;
    for (int k = 1; k < NST; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // fold, angle, square
    a_r    <= a_w[13:0];
    xp_r   <= 46'(a_r) * 46'(PI_Q30);
    x3_r   <= xp_r[44:15];
    x2p_r  <= 60'(xp_r[44:15]) * 60'(xp_r[44:15]);
    // first term of each series
    x2_4_r <= x2p_r[59:30];
    x_4_r  <= x3_r;
    ps_r   <= 60'(x2p_r[59:30]) * 60'(SIN_RCP0);
    pc_r   <= 60'(x2p_r[59:30]) * 60'(COS_RCP0);
    ts_q[0] <= Q30_ONE - 31'(fix_quot(ps_r[59:32], x2_4_r, SIN_DIV0));
    tc_q[0] <= Q30_ONE - 31'(fix_quot(pc_r[59:32], x2_4_r, COS_DIV0));
    x2_q[0] <= x2_4_r;
    x_q[0]  <= x_4_r;
    // Horner steps: multiply, reciprocal, correct and subtract
    for (int k = 0; k < NSTEP; k++) begin
      ms_r[k]  <= 60'(x2_q[k]) * 60'(ts_q[k]);
      mc_r[k]  <= 60'(x2_q[k]) * 60'(tc_q[k]);
      x2a_r[k] <= x2_q[k];
      xa_r[k]  <= x_q[k];
      vs_r[k]  <= ms_r[k][59:30];
      vc_r[k]  <= mc_r[k][59:30];
      ds_r[k]  <= 60'(ms_r[k][59:30]) * 60'(SIN_RCP[k]);
      dc_r[k]  <= 60'(mc_r[k][59:30]) * 60'(COS_RCP[k]);
      x2b_r[k] <= x2a_r[k];
      xb_r[k]  <= xa_r[k];
      ts_q[k+1] <= Q30_ONE - 31'(fix_quot(ds_r[k][59:32], vs_r[k], SIN_DIV[k]));
      tc_q[k+1] <= Q30_ONE - 31'(fix_quot(dc_r[k][59:32], vc_r[k], COS_DIV[k]));
      x2_q[k+1] <= x2b_r[k];
      x_q[k+1]  <= xb_r[k];
    end
    // last products, then rounding
    so_p_r <= 60'(x_q[NSTEP]) * 60'(ts_q[NSTEP]);
    co_p_r <= 60'(x2_q[NSTEP]) * 60'(tc_q[NSTEP]);
    sn_r   <= sn_w;
    cs_r   <= cs_w;
  end

  assign trig_out.valid = vld_r[NST-1];
  assign trig_out.job   = side_r[NST-1].job;
  assign trig_out.u     = side_r[NST-1].u;
  assign trig_out.s     = sn_r;
  assign trig_out.c     = cs_r;

endmodule

>>> design/csvg_emit.sv
`timescale 1ns / 1ps

module csvg_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csvg_pkg::trig_t                     trig_in,
  input  logic [csvg_pkg::RAD_W-1:0]          top_radius,
  input  logic [csvg_pkg::RAD_W-1:0]          bottom_radius,
  input  logic signed [csvg_pkg::DAT_W-1:0]   height,
  output logic                                out_valid,
  output logic [2:0]                          out_corner,
  output logic signed [csvg_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [csvg_pkg::DAT_W-1:0]   out_pos_y,
  output logic signed [csvg_pkg::POS_W-1:0]   out_pos_z,
  output logic [csvg_pkg::U_W-1:0]            out_tex_u,
  output logic                                out_tex_v,
  output logic signed [csvg_pkg::TRIG_W-1:0]  out_normal_x,
  output logic signed [csvg_pkg::TRIG_W-1:0]  out_normal_z,
  output logic                                out_last
);
  import csvg_pkg::*;

  // Edge 0 waits here until edge 1 arrives
  logic [U_W-1:0]           h_u_r;
  logic signed [TRIG_W-1:0] h_s_r, h_c_r;

  // Segment being emitted
  logic [U_W-1:0]           u0_r, u1_r;
  logic signed [TRIG_W-1:0] s0_r, c0_r, s1_r, c1_r;
  corner_t                  cnt_r;
  logic                     act_r;

  // Multiply stage
  logic                     m_vld_r;
  corner_t                  m_crn_r;
  logic [30:0]              m_mx_r, m_mz_r;
  logic                     m_negx_r, m_negz_r, m_bot_r;
  logic [U_W-1:0]           m_u_r;
  logic signed [TRIG_W-1:0] m_nx_r, m_nz_r;

  // Output stage
  logic                     o_vld_r;
  logic [2:0]               o_crn_r;
  logic signed [POS_W-1:0]  o_px_r, o_pz_r;
  logic signed [DAT_W-1:0]  o_py_r;
  logic [U_W-1:0]           o_u_r;
  logic                     o_v_r, o_last_r;
  logic signed [TRIG_W-1:0] o_nx_r, o_nz_r;

  // Pick edge and ring for the current corner
  logic                     edge1_w, bot_w;
  logic signed [TRIG_W-1:0] s_w, c_w, ms_w, mc_w;
  logic [U_W-1:0]           u_w;
  logic [RAD_W-1:0]         rad_w;

  always_comb begin
    unique case (cnt_r)
      CRN_TOP0: begin
        edge1_w = 1'b0;
        bot_w   = 1'b0;
      end
      CRN_BOT0_A, CRN_BOT0_B: begin
        edge1_w = 1'b0;
        bot_w   = 1'b1;
      end
      CRN_TOP1_A, CRN_TOP1_B: begin
        edge1_w = 1'b1;
        bot_w   = 1'b0;
      end
      CRN_BOT1: begin
        edge1_w = 1'b1;
        bot_w   = 1'b1;
      end
      default: begin
        edge1_w = 1'b0;
        bot_w   = 1'b0;
      end
    endcase
    s_w   = edge1_w ? s1_r : s0_r;
    c_w   = edge1_w ? c1_r : c0_r;
    u_w   = edge1_w ? u1_r : u0_r;
    rad_w = bot_w ? bottom_radius : top_radius;
    ms_w  = s_w[TRIG_W-1] ? -s_w : s_w;
    mc_w  = c_w[TRIG_W-1] ? -c_w : c_w;
  end

  // Collect edges and step through the six corners
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= CRN_TOP0;
    end else if (trig_in.valid && trig_in.job) begin
      act_r <= 1'b1;
      cnt_r <= CRN_TOP0;
    end else if (act_r) begin
      if (cnt_r == CRN_TOP1_B) begin
        act_r <= 1'b0;
      end else begin
        cnt_r <= corner_t'(cnt_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (trig_in.valid && !trig_in.job) begin
      h_u_r <= trig_in.u;
      h_s_r <= trig_in.s;
      h_c_r <= trig_in.c;
    end
    if (trig_in.valid && trig_in.job) begin
      u0_r <= h_u_r;
      s0_r <= h_s_r;
      c0_r <= h_c_r;
      u1_r <= trig_in.u;
      s1_r <= trig_in.s;
      c1_r <= trig_in.c;
    end
  end

  // Scale by radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    m_crn_r  <= cnt_r;
    m_mx_r   <= 31'(ms_w[TRIG_W-2:0]) * 31'(rad_w);
    m_mz_r   <= 31'(mc_w[TRIG_W-2:0]) * 31'(rad_w);
    m_negx_r <= (s_w > 0);
    m_negz_r <= c_w[TRIG_W-1];
    m_bot_r  <= bot_w;
    m_u_r    <= u_w;
    m_nx_r   <= -s_w;
    m_nz_r   <= c_w;
  end

  // Round half away from zero and register the result
  logic [30:0]             rx_w, rz_w;
  logic signed [POS_W-1:0] px_w, pz_w;

  always_comb begin
    rx_w = m_mx_r + 31'd8192;
    rz_w = m_mz_r + 31'd8192;
    px_w = {1'b0, rx_w[30:14]};
    pz_w = {1'b0, rz_w[30:14]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    o_crn_r  <= m_crn_r;
    o_px_r   <= m_negx_r ? -px_w : px_w;
    o_pz_r   <= m_negz_r ? -pz_w : pz_w;
    o_py_r   <= m_bot_r ? '0 : height;
    o_u_r    <= m_u_r;
    o_v_r    <= m_bot_r;
    o_nx_r   <= m_nx_r;
    o_nz_r   <= m_nz_r;
    o_last_r <= (m_crn_r == CRN_TOP1_B);
  end

  assign out_valid    = o_vld_r;
  assign out_corner   = o_crn_r;
  assign out_pos_x    = o_px_r;
  assign out_pos_y    = o_py_r;
  assign out_pos_z    = o_pz_r;
  assign out_tex_u    = o_u_r;
  assign out_tex_v    = o_v_r;
  assign out_normal_x = o_nx_r;
  assign out_normal_z = o_nz_r;
  assign out_last     = o_last_r;

endmodule

>>> design/cylinder_side_vertex_generator_top.sv
`timescale 1ns / 1ps
// Side wall vertex generator for a tapered cylinder.
// Input: pulse start with in_segment_index while busy is low; the item is
// taken at that edge. Each item gives six vertices (two triangles) on the
// out_ ports, one per cycle, each marked by out_valid for one cycle, with
// out_last on the sixth. The receiver cannot hold results off.
// Configuration: cfg_wr_en, cfg_index, cfg_data write segments, top radius,
// bottom radius and height; write only while no item is in flight.
// Path: the start edge passes the issue register, an 18-stage restoring
// divider for the phases and a 16-stage sine/cosine pipeline, waits for the
// second phase, then passes a corner, a multiply and a rounding stage before
// the first vertex appears. Busy goes high after each accepted item and holds
// off the next one, so the six-vertex result streams of successive items do
// not overlap. Both phases of an item share the divider and sine/cosine
// pipelines in consecutive cycles.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults (32 segments, radii 1.0, height 1.0).
module cylinder_side_vertex_generator_top #(
  parameter int MAX_SEGMENTS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [csvg_pkg::IDX_W-1:0]          in_segment_index,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [csvg_pkg::DAT_W-1:0]          cfg_data,
  output logic                                out_valid,
  output logic [2:0]                          out_corner,
  output logic signed [csvg_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [csvg_pkg::DAT_W-1:0]   out_pos_y,
  output logic signed [csvg_pkg::POS_W-1:0]   out_pos_z,
  output logic [csvg_pkg::U_W-1:0]            out_tex_u,
  output logic                                out_tex_v,
  output logic signed [csvg_pkg::TRIG_W-1:0]  out_normal_x,
  output logic signed [csvg_pkg::TRIG_W-1:0]  out_normal_z,
  output logic                                out_last
);
  import csvg_pkg::*;

  localparam logic [SEG_W-1:0] SEG_CAP =
    (MAX_SEGMENTS > 8191) ? SEG_CFG_MAX : SEG_W'(MAX_SEGMENTS);

  // Configuration registers
  logic [SEG_W-1:0]        seg_r;
  logic [RAD_W-1:0]        top_rad_r, bot_rad_r;
  logic signed [DAT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= 13'd32;
      top_rad_r <= 16'd256;
      bot_rad_r <= 16'd256;
      height_r  <= 16'sd256;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEGMENTS:      seg_r     <= cfg_data[SEG_W-1:0];
        REG_TOP_RADIUS:    top_rad_r <= cfg_data;
        REG_BOTTOM_RADIUS: bot_rad_r <= cfg_data;
        REG_HEIGHT:        height_r  <= cfg_data;
      endcase
    end
  end

  // Clamp segment count and index
  logic [SEG_W-1:0] seg_lo_w, seg_w, idx_w;
  logic             accept_w;

  always_comb begin
    seg_lo_w = (seg_r < SEG_MIN) ? SEG_MIN : seg_r;
    seg_w    = (seg_lo_w > SEG_CAP) ? SEG_CAP : seg_lo_w;
    idx_w    = (SEG_W'(in_segment_index) >= seg_w) ? (seg_w - 13'd1)
                                                   : SEG_W'(in_segment_index);
    accept_w = start && !busy;
  end

  // Hold off new items after each accepted one
  logic [2:0] gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (accept_w) begin
      gap_r <= 3'd5;
    end else if (gap_r != 3'd0) begin
      gap_r <= gap_r - 3'd1;
    end
  end

  assign busy = (gap_r != 3'd0);

  // Issue both edges of the segment, one per cycle
  logic             iss_vld_r, iss_job_r;
  logic [SEG_W-1:0] iss_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_vld_r <= 1'b0;
      iss_job_r <= 1'b0;
    end else if (accept_w) begin
      iss_vld_r <= 1'b1;
      iss_job_r <= 1'b0;
    end else if (iss_vld_r && !iss_job_r) begin
      iss_job_r <= 1'b1;
    end else begin
      iss_vld_r <= 1'b0;
      iss_job_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_w) begin
      iss_idx_r <= idx_w;
    end else if (iss_vld_r && !iss_job_r) begin
      iss_idx_r <= iss_idx_r + 13'd1;
    end
  end

  // Phase = round(index * 65536 / segments)
  logic [DVD_W-1:0] dvd_w;
  assign dvd_w = {iss_idx_r, 16'd0} + DVD_W'(seg_w >> 1);

  phase_t ph_w;
  trig_t  trig_w;

  csvg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (iss_vld_r),
    .in_job   (iss_job_r),
    .dividend (dvd_w),
    .divisor  (seg_w),
    .ph_out   (ph_w)
  );

  csvg_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .ph_in    (ph_w),
    .trig_out (trig_w)
  );

  csvg_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .trig_in       (trig_w),
    .top_radius    (top_rad_r),
    .bottom_radius (bot_rad_r),
    .height        (height_r),
    .out_valid     (out_valid),
    .out_corner    (out_corner),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_tex_u     (out_tex_u),
    .out_tex_v     (out_tex_v),
    .out_normal_x  (out_normal_x),
    .out_normal_z  (out_normal_z),
    .out_last      (out_last)
  );

endmodule

>>> design/csvg_checker.sv
`timescale 1ns / 1ps

module csvg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_corner,
  input logic       out_tex_v,
  input logic       out_last
);
  import csvg_pkg::*;

  // An accepted item blocks the next one
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after an accepted item");

  // Last flag only on the sixth vertex
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_corner == CRN_TOP1_B)
    else $error("out_last on a corner other than the sixth");

  // Vertices of a segment come back to back in corner order
  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner != CRN_TOP1_B) |=>
      out_valid && (out_corner == $past(out_corner) + 3'd1))
    else $error("segment vertex stream broken");

  // Bottom ring corners carry v = 1
  a_tex_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_v == (out_corner == CRN_BOT0_A ||
                                out_corner == CRN_BOT0_B ||
                                out_corner == CRN_BOT1))
    else $error("tex_v does not match ring of corner");

endmodule

bind cylinder_side_vertex_generator_top csvg_checker u_csvg_checker (.*);
